### hdl/reply_prefix_subject_start_finder_macros.svh
// assertion helpers used by the checker file
`ifndef REPLY_PREFIX_SUBJECT_START_FINDER_MACROS_SVH
`define REPLY_PREFIX_SUBJECT_START_FINDER_MACROS_SVH

// same-cycle implication, disabled during reset
`define RPSF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rpsf check failed");

// next-cycle implication, disabled during reset
`define RPSF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rpsf check failed");

`endif

### hdl/rpsf_pkg.sv
`timescale 1ns / 1ps

package rpsf_pkg;

    localparam int MAX_SUBJECT_LEN_DEFAULT = 4096;
    localparam int OFF_W   = 12;
    localparam int DATA_W  = 16;
    localparam int CHAR_W  = 8;
    localparam int PHASE_W = 4;

    // matcher phases
    localparam logic [PHASE_W-1:0] PH_LEAD     = 4'd0;
    localparam logic [PHASE_W-1:0] PH_R        = 4'd1;
    localparam logic [PHASE_W-1:0] PH_F        = 4'd2;
    localparam logic [PHASE_W-1:0] PH_FW       = 4'd3;
    localparam logic [PHASE_W-1:0] PH_KEYWORD  = 4'd4;
    localparam logic [PHASE_W-1:0] PH_BRACKET  = 4'd5;
    localparam logic [PHASE_W-1:0] PH_DIGITS   = 4'd6;
    localparam logic [PHASE_W-1:0] PH_BR_SPACE = 4'd7;
    localparam logic [PHASE_W-1:0] PH_COLON    = 4'd8;

    typedef struct packed {
        logic               ok;
        logic               commit;
        logic [PHASE_W-1:0] phase;
    } match_res_t;

endpackage

### hdl/rpsf_match.sv
`timescale 1ns / 1ps

module rpsf_match (
    input  logic [rpsf_pkg::PHASE_W-1:0] phase,
    input  logic [rpsf_pkg::CHAR_W-1:0]  char_byte,
    output rpsf_pkg::match_res_t         res
);

    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_E      = 8'h65;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_W      = 8'h77;
    localparam logic [7:0] CH_D      = 8'h64;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_COLON  = 8'h3A;

    logic       ws;
    logic       digit;
    logic [7:0] lc;

    always_comb
    begin
        ws    = (char_byte == 8'h20) || (char_byte >= 8'h09 && char_byte <= 8'h0D);
        digit = (char_byte >= 8'h30) && (char_byte <= 8'h39);
        lc    = (char_byte >= 8'h41 && char_byte <= 8'h5A) ? char_byte + 8'h20 : char_byte;
    end

    always_comb
    begin
        res.ok     = 1'b0;
        res.commit = 1'b0;
        res.phase  = phase;
        unique case (phase)
            rpsf_pkg::PH_LEAD, rpsf_pkg::PH_COLON:
            begin
                if (ws)
                begin
                    res.ok     = 1'b1;
                    // whitespace after a colon extends the committed prefix
                    res.commit = (phase == rpsf_pkg::PH_COLON);
                end
                else if (lc == CH_R)
                begin
                    res.ok    = 1'b1;
                    res.phase = rpsf_pkg::PH_R;
                end
                else if (lc == CH_F)
                begin
                    res.ok    = 1'b1;
                    res.phase = rpsf_pkg::PH_F;
                end
            end
            rpsf_pkg::PH_R:
            begin
                if (lc == CH_E)
                begin
                    res.ok    = 1'b1;
                    res.phase = rpsf_pkg::PH_KEYWORD;
                end
            end
            rpsf_pkg::PH_F:
            begin
                if (lc == CH_W)
                begin
                    res.ok    = 1'b1;
                    res.phase = rpsf_pkg::PH_FW;
                end
            end
            rpsf_pkg::PH_FW:
            begin
                if (lc == CH_D)
                begin
                    res.ok    = 1'b1;
                    res.phase = rpsf_pkg::PH_KEYWORD;
                end
            end
            rpsf_pkg::PH_KEYWORD:
            begin
                if (char_byte == CH_LBRACK)
                begin
                    res.ok    = 1'b1;
                    res.phase = rpsf_pkg::PH_BRACKET;
                end
                else if (char_byte == CH_COLON)
                begin
                    res.ok     = 1'b1;
                    res.commit = 1'b1;
                    res.phase  = rpsf_pkg::PH_COLON;
                end
            end
            rpsf_pkg::PH_BRACKET:
            begin
                if (digit)
                begin
                    res.ok    = 1'b1;
                    res.phase = rpsf_pkg::PH_DIGITS;
                end
            end
            rpsf_pkg::PH_DIGITS:
            begin
                if (digit)
                begin
                    res.ok = 1'b1;
                end
                else if (char_byte == CH_RBRACK)
                begin
                    res.ok    = 1'b1;
                    res.phase = rpsf_pkg::PH_BR_SPACE;
                end
            end
            rpsf_pkg::PH_BR_SPACE:
            begin
                if (ws)
                begin
                    res.ok = 1'b1;
                end
                else if (char_byte == CH_COLON)
                begin
                    res.ok     = 1'b1;
                    res.commit = 1'b1;
                    res.phase  = rpsf_pkg::PH_COLON;
                end
            end
            default:
            begin
                res.ok = 1'b0;
            end
        endcase
    end

endmodule

### hdl/rpsf_out.sv
`timescale 1ns / 1ps

module rpsf_out (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  logic [rpsf_pkg::OFF_W-1:0]  start_offset,
    input  logic                        too_long,
    output logic                        can_load,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [rpsf_pkg::DATA_W-1:0] m_tdata,   // start_offset[11:0], zero fill
    output logic                        m_tuser    // too_long
);

    logic                       valid_reg;
    logic                       valid_next;
    logic [rpsf_pkg::OFF_W-1:0] offset_reg;
    logic                       too_long_reg;

    // register is free when empty or being drained this cycle
    assign can_load = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            offset_reg   <= start_offset;
            too_long_reg <= too_long;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(rpsf_pkg::DATA_W - rpsf_pkg::OFF_W){1'b0}}, offset_reg};
    assign m_tuser  = too_long_reg;

endmodule

### hdl/reply_prefix_subject_start_finder.sv
`timescale 1ns / 1ps
// one byte accepted per cycle, back to back, while the result register is free or draining
// result appears on the master side in the cycle after the deciding byte is accepted
// at most one result per string; the remaining bytes of a decided string are consumed silently
// asynchronous active-low reset returns the matcher to the leading whitespace phase
// and empties the result register

module reply_prefix_subject_start_finder #(
    parameter int MAX_SUBJECT_LEN = rpsf_pkg::MAX_SUBJECT_LEN_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [rpsf_pkg::CHAR_W-1:0] s_tdata,   // char_byte
    input  logic                        s_tlast,   // is_final
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [rpsf_pkg::DATA_W-1:0] m_tdata,   // start_offset[11:0], zero fill
    output logic                        m_tuser    // too_long
);

    localparam int POS_W = $clog2(MAX_SUBJECT_LEN);
    localparam int EXT_W = (POS_W > rpsf_pkg::OFF_W) ? POS_W : rpsf_pkg::OFF_W;
    localparam logic [POS_W-1:0] OFFSET_CAP = POS_W'(MAX_SUBJECT_LEN - 1);

    logic [rpsf_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic [POS_W-1:0]             pos_reg, pos_next;
    logic [POS_W-1:0]             committed_reg, committed_next;
    logic                         sent_reg, sent_next;
    logic                         ovf_reg, ovf_next;

    rpsf_pkg::match_res_t         mres;
    logic                         accept;
    logic                         at_cap;
    logic [POS_W-1:0]             pos_step;
    logic [POS_W-1:0]             committed_step;
    logic [EXT_W-1:0]             committed_ext;
    logic                         ovf_step;
    logic                         emit;
    logic                         can_load;

    rpsf_match u_match (
        .phase     (phase_reg),
        .char_byte (s_tdata),
        .res       (mres)
    );

    assign s_tready = can_load;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        at_cap         = (pos_reg >= OFFSET_CAP);
        pos_step       = at_cap ? OFFSET_CAP : pos_reg + 1'b1;
        ovf_step       = ovf_reg || at_cap;
        committed_step = mres.commit ? pos_step : committed_reg;
        committed_ext  = EXT_W'(committed_step);
        emit           = accept && !sent_reg && (!mres.ok || s_tlast);

        phase_next     = phase_reg;
        pos_next       = pos_reg;
        committed_next = committed_reg;
        sent_next      = sent_reg;
        ovf_next       = ovf_reg;
        if (accept)
        begin
            if (s_tlast)
            begin
                phase_next     = rpsf_pkg::PH_LEAD;
                pos_next       = '0;
                committed_next = '0;
                sent_next      = 1'b0;
                ovf_next       = 1'b0;
            end
            else if (!sent_reg)
            begin
                phase_next     = mres.phase;
                pos_next       = pos_step;
                committed_next = committed_step;
                ovf_next       = ovf_step;
                sent_next      = !mres.ok;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= rpsf_pkg::PH_LEAD;
            pos_reg       <= '0;
            committed_reg <= '0;
            sent_reg      <= 1'b0;
            ovf_reg       <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            committed_reg <= committed_next;
            sent_reg      <= sent_next;
            ovf_reg       <= ovf_next;
        end
    end

    rpsf_out u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (emit),
        .start_offset (committed_ext[rpsf_pkg::OFF_W-1:0]),
        .too_long     (ovf_step),
        .can_load     (can_load),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser)
    );

endmodule

### hdl/rpsf_checker.sv
`timescale 1ns / 1ps
`include "reply_prefix_subject_start_finder_macros.svh"

module rpsf_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [rpsf_pkg::DATA_W-1:0] m_tdata,
    input logic                        m_tuser
);

    // a stalled result beat holds
    `RPSF_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable({m_tdata, m_tuser}))

    // input side never stalls while the result register is empty
    `RPSF_ASSERT_NOW(a_ready_when_empty, !m_tvalid, s_tready)

    // a new result only follows an accepted input beat
    `RPSF_ASSERT_NOW(a_result_cause, $rose(m_tvalid), $past(s_tvalid && s_tready))

    // padding bits above the offset stay zero
    `RPSF_ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[15:12] == 4'h0)

endmodule

bind reply_prefix_subject_start_finder rpsf_checker u_rpsf_checker (.*);
